// ===== hw/rtl/prc_pkg.sv =====
`default_nettype none

package prc_pkg;

   // Field widths of the channel words.
   localparam int REQ_W    = 2;
   localparam int ADDR_W   = 48;
   localparam int INDEX_W  = 3;
   localparam int STATUS_W = 3;
   localparam int USE_W    = 8;
   localparam int FREE_W   = 4;
   localparam int CSR_W    = 4;

   // Value of the active entry register after reset.
   localparam int ACTIVE_RESET = 8;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_GET  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PUT  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FILL = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT_READY   = 3'd0,
      ST_HIT_PENDING = 3'd1,
      ST_MISS_ALLOC  = 3'd2,
      ST_ALL_LOCKED  = 3'd3,
      ST_RELEASED    = 3'd4,
      ST_STILL_HELD  = 3'd5,
      ST_FILL_DONE   = 3'd6,
      ST_BAD_REQUEST = 3'd7
   } status_type;

   // Operation decided at lookup, registered, and carried out by the cells in the update state.
   typedef enum logic [2:0] {
      OP_HIT    = 3'd0,
      OP_ALLOC  = 3'd1,
      OP_LOCKED = 3'd2,
      OP_PUT    = 3'd3,
      OP_FILL   = 3'd4,
      OP_BAD    = 3'd5
   } op_type;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [ADDR_W-1:0]  block_addr;
      logic [INDEX_W-1:0] entry_index;
      logic               fill_error;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  entry_slot;
      logic                entry_failed;
      logic [USE_W-1:0]    use_count;
      logic [FREE_W-1:0]   free_count;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_W-1:0] active_entries;
   } csr_word_type;

   // Flags that ripple along the row of cells during a lookup.
   typedef struct packed {
      logic hit;
      logic upper;
      logic any;
   } link_type;

   typedef struct packed {
      logic valid;
      logic pend;
      logic err;
   } flags_type;

   typedef struct packed {
      op_type op;
      logic   go;
      logic   fill_error;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/prc_chan_if.sv =====
`default_nettype none

interface prc_chan_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prc_cell.sv =====
`default_nettype none

module prc_cell import prc_pkg::*; #(
   parameter int INDEX     = 0,
   parameter int TAG_WIDTH = 48,
   parameter int PIN_WIDTH = 8,
   parameter int IDX_W     = 3,
   parameter int CNT_W     = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CNT_W-1:0]     live,
   input  wire logic [IDX_W-1:0]     victim,
   input  wire logic [TAG_WIDTH-1:0] lookup_tag,
   input  wire cmd_type              cmd,
   input  wire logic [IDX_W-1:0]     cmd_slot,
   input  wire logic [TAG_WIDTH-1:0] cmd_tag,
   input  wire link_type             link_i,
   input  wire logic [IDX_W-1:0]     hit_idx_i,
   input  wire logic [IDX_W-1:0]     upper_idx_i,
   input  wire logic [IDX_W-1:0]     any_idx_i,
   input  wire logic [CNT_W-1:0]     free_i,
   output link_type                  link_o,
   output logic [IDX_W-1:0]          hit_idx_o,
   output logic [IDX_W-1:0]          upper_idx_o,
   output logic [IDX_W-1:0]          any_idx_o,
   output logic [CNT_W-1:0]          free_o,
   output flags_type                 flags_cur,
   output flags_type                 flags_nxt,
   output logic [PIN_WIDTH-1:0]      pin_cur,
   output logic [PIN_WIDTH-1:0]      pin_nxt
);

   localparam logic [IDX_W-1:0]     MY_IDX   = IDX_W'(INDEX);
   localparam logic [PIN_WIDTH-1:0] PIN_FULL = '1;

   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 valid_ff, valid_in;
   logic [PIN_WIDTH-1:0] pin_ff, pin_in;
   logic                 pend_ff, pend_in;
   logic                 err_ff, err_in;

   logic live_here;
   logic match;
   logic free_here;
   logic upper_here;
   logic slot_sel;

   assign live_here  = CNT_W'(INDEX) < live;
   assign match      = valid_ff && live_here && (tag_ff == lookup_tag);
   assign free_here  = live_here && (pin_ff == '0);
   assign upper_here = free_here && (MY_IDX >= victim);
   assign slot_sel   = (cmd_slot == MY_IDX);

   // The lowest matching entry wins, and the first free entry at or after the
   // victim pointer is preferred over the first free entry overall.
   assign link_o.hit   = link_i.hit || match;
   assign link_o.upper = link_i.upper || upper_here;
   assign link_o.any   = link_i.any || free_here;
   assign hit_idx_o    = link_i.hit ? hit_idx_i : MY_IDX;
   assign upper_idx_o  = link_i.upper ? upper_idx_i : MY_IDX;
   assign any_idx_o    = link_i.any ? any_idx_i : MY_IDX;
   assign free_o       = free_i + CNT_W'(free_here);

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      pin_in   = pin_ff;
      pend_in  = pend_ff;
      err_in   = err_ff;
      if (slot_sel) begin
         unique case (cmd.op)
            OP_HIT: begin
               if (pin_ff != PIN_FULL) pin_in = pin_ff + PIN_WIDTH'(1);
            end
            OP_ALLOC: begin
               tag_in   = cmd_tag;
               valid_in = 1'b1;
               pin_in   = PIN_WIDTH'(1);
               pend_in  = 1'b1;
               err_in   = 1'b0;
            end
            OP_PUT: begin
               if (pin_ff != '0) pin_in = pin_ff - PIN_WIDTH'(1);
            end
            OP_FILL: begin
               if (valid_ff && pend_ff) begin
                  pend_in = 1'b0;
                  err_in  = cmd.fill_error;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pin_ff   <= '0;
         pend_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else if (cmd.go) begin
         valid_ff <= valid_in;
         pin_ff   <= pin_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) tag_ff <= tag_in;
   end

   assign flags_cur = '{valid: valid_ff, pend: pend_ff, err: err_ff};
   assign flags_nxt = '{valid: valid_in, pend: pend_in, err: err_in};
   assign pin_cur   = pin_ff;
   assign pin_nxt   = pin_in;

endmodule

`default_nettype wire

// ===== hw/rtl/pinned_round_robin_block_cache.sv =====
// Tag and pin manager for a small fully associative block cache.
// req_ch carries one request word: a get looks up block_addr and pins a hit
// or allocates the next unpinned entry in round-robin order; a put unpins
// entry_index; a fill done clears the pending mark of entry_index and records
// fill_error. rsp_ch returns exactly one result word per request.
// csr_ch writes the number of active entries; it is taken only while no
// request is in flight, and the block then recounts the free entries in a
// recount state before it takes the next request.
// For a request, the accepting cycle runs the tag compare and
// the rotating free-entry pick along the row of entry cells, and the update
// state then updates the chosen cell and loads the result register. A new
// request is not taken until the current one has loaded its result.
// If the receiver stalls, the result register holds its word and a request
// taken meanwhile waits in the update cycle until the register is free.
// Reset clears every entry, points the victim pointer at entry 0 and sets
// the active count to eight (or ENTRIES, if smaller).
`default_nettype none

module pinned_round_robin_block_cache import prc_pkg::*; #(
   parameter int ENTRIES   = 8,
   parameter int TAG_WIDTH = 48,
   parameter int PIN_WIDTH = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   prc_chan_if.sink   req_ch,
   prc_chan_if.source rsp_ch,
   prc_chan_if.sink   csr_ch
);

   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int LIVE_RESET = (ENTRIES < ACTIVE_RESET) ? ENTRIES : ACTIVE_RESET;

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_RECOUNT = 3'b010,
      S_APPLY   = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     live_ff, live_in;
   logic [IDX_W-1:0]     victim_ff, victim_in;
   logic [CNT_W-1:0]     unpinned_ff, unpinned_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   op_type               op_ff, op_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 ferr_ff, ferr_in;
   logic                 show_ff, show_in;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 apply_fire;
   logic [TAG_WIDTH-1:0] lookup_tag;
   cmd_type              cmd;

   link_type             link_w      [ENTRIES+1];
   logic [IDX_W-1:0]     hit_idx_w   [ENTRIES+1];
   logic [IDX_W-1:0]     upper_idx_w [ENTRIES+1];
   logic [IDX_W-1:0]     any_idx_w   [ENTRIES+1];
   logic [CNT_W-1:0]     free_w      [ENTRIES+1];
   flags_type            flags_cur_w [ENTRIES];
   flags_type            flags_nxt_w [ENTRIES];
   logic [PIN_WIDTH-1:0] pin_cur_w   [ENTRIES];
   logic [PIN_WIDTH-1:0] pin_nxt_w   [ENTRIES];

   flags_type            sel_cur;
   flags_type            sel_nxt;
   logic [PIN_WIDTH-1:0] sel_pin_cur;
   logic [PIN_WIDTH-1:0] sel_pin_nxt;

   assign req_ch.ready = (state_ff == S_IDLE) && !csr_ch.valid;
   assign csr_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign csr_fire   = csr_ch.valid && csr_ch.ready;
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ch.ready);
   assign lookup_tag = TAG_WIDTH'(req_ch.word.block_addr);
   assign cmd        = '{op: op_ff, go: apply_fire, fill_error: ferr_ff};

   assign link_w[0]      = '0;
   assign hit_idx_w[0]   = '0;
   assign upper_idx_w[0] = '0;
   assign any_idx_w[0]   = '0;
   assign free_w[0]      = '0;

   genvar gi;
   for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      prc_cell #(
         .INDEX     (gi),
         .TAG_WIDTH (TAG_WIDTH),
         .PIN_WIDTH (PIN_WIDTH),
         .IDX_W     (IDX_W),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .live        (live_ff),
         .victim      (victim_ff),
         .lookup_tag  (lookup_tag),
         .cmd         (cmd),
         .cmd_slot    (slot_ff),
         .cmd_tag     (tag_ff),
         .link_i      (link_w[gi]),
         .hit_idx_i   (hit_idx_w[gi]),
         .upper_idx_i (upper_idx_w[gi]),
         .any_idx_i   (any_idx_w[gi]),
         .free_i      (free_w[gi]),
         .link_o      (link_w[gi+1]),
         .hit_idx_o   (hit_idx_w[gi+1]),
         .upper_idx_o (upper_idx_w[gi+1]),
         .any_idx_o   (any_idx_w[gi+1]),
         .free_o      (free_w[gi+1]),
         .flags_cur   (flags_cur_w[gi]),
         .flags_nxt   (flags_nxt_w[gi]),
         .pin_cur     (pin_cur_w[gi]),
         .pin_nxt     (pin_nxt_w[gi])
      );
   end

   assign sel_cur     = flags_cur_w[slot_ff];
   assign sel_nxt     = flags_nxt_w[slot_ff];
   assign sel_pin_cur = pin_cur_w[slot_ff];
   assign sel_pin_nxt = pin_nxt_w[slot_ff];

   // Lookup: decode the request and register the pick from the end of the row.
   always_comb begin
      op_in   = op_ff;
      slot_in = slot_ff;
      idx_in  = idx_ff;
      tag_in  = tag_ff;
      ferr_in = ferr_ff;
      show_in = show_ff;
      if (req_fire) begin
         idx_in  = req_ch.word.entry_index;
         tag_in  = lookup_tag;
         ferr_in = req_ch.word.fill_error;
         show_in = 32'(req_ch.word.entry_index) < ENTRIES;
         slot_in = show_in ? IDX_W'(req_ch.word.entry_index) : '0;
         unique case (req_ch.word.req_type)
            REQ_GET: begin
               if (link_w[ENTRIES].hit) begin
                  op_in   = OP_HIT;
                  slot_in = hit_idx_w[ENTRIES];
               end else if (link_w[ENTRIES].any) begin
                  op_in   = OP_ALLOC;
                  slot_in = link_w[ENTRIES].upper ? upper_idx_w[ENTRIES]
                                                  : any_idx_w[ENTRIES];
               end else begin
                  op_in   = OP_LOCKED;
                  slot_in = '0;
               end
            end
            REQ_PUT: begin
               op_in = (32'(req_ch.word.entry_index) < 32'(live_ff)) ? OP_PUT : OP_BAD;
            end
            REQ_FILL: begin
               op_in = (32'(req_ch.word.entry_index) < 32'(live_ff)) ? OP_FILL : OP_BAD;
            end
            default: begin
               op_in = OP_BAD;
            end
         endcase
      end
   end

   // Update: form the result word from the chosen cell before and after its
   // update, and keep the free count and victim pointer in step.
   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      victim_in    = victim_ff;
      unpinned_in  = unpinned_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               if (csr_ch.word.active_entries == '0) begin
                  live_in = CNT_W'(1);
               end else if (32'(csr_ch.word.active_entries) > ENTRIES) begin
                  live_in = CNT_W'(ENTRIES);
               end else begin
                  live_in = CNT_W'(csr_ch.word.active_entries);
               end
               if (CNT_W'(victim_ff) >= live_in) victim_in = '0;
               state_in = S_RECOUNT;
            end else if (req_fire) begin
               state_in = S_APPLY;
            end
         end
         S_RECOUNT: begin
            unpinned_in = free_w[ENTRIES];
            state_in    = S_IDLE;
         end
         S_APPLY: begin
            if (apply_fire) begin
               rsp_word_in.entry_slot   = idx_ff;
               rsp_word_in.entry_failed = sel_nxt.err;
               rsp_word_in.use_count    = USE_W'(sel_pin_nxt);
               unique case (op_ff)
                  OP_HIT: begin
                     rsp_word_in.status     = sel_cur.pend ? ST_HIT_PENDING : ST_HIT_READY;
                     rsp_word_in.entry_slot = INDEX_W'(slot_ff);
                     if (sel_pin_cur == '0 && unpinned_ff != '0) begin
                        unpinned_in = unpinned_ff - CNT_W'(1);
                     end
                  end
                  OP_ALLOC: begin
                     rsp_word_in.status     = ST_MISS_ALLOC;
                     rsp_word_in.entry_slot = INDEX_W'(slot_ff);
                     if (unpinned_ff != '0) unpinned_in = unpinned_ff - CNT_W'(1);
                     if ((CNT_W'(slot_ff) + CNT_W'(1)) < live_ff) begin
                        victim_in = slot_ff + IDX_W'(1);
                     end else begin
                        victim_in = '0;
                     end
                  end
                  OP_LOCKED: begin
                     rsp_word_in.status       = ST_ALL_LOCKED;
                     rsp_word_in.entry_slot   = '0;
                     rsp_word_in.entry_failed = 1'b0;
                     rsp_word_in.use_count    = '0;
                  end
                  OP_PUT: begin
                     if (sel_pin_cur == '0) begin
                        rsp_word_in.status = ST_BAD_REQUEST;
                     end else if (sel_pin_nxt == '0) begin
                        rsp_word_in.status = ST_RELEASED;
                        unpinned_in        = unpinned_ff + CNT_W'(1);
                     end else begin
                        rsp_word_in.status = ST_STILL_HELD;
                     end
                  end
                  OP_FILL: begin
                     rsp_word_in.status = (sel_cur.valid && sel_cur.pend) ? ST_FILL_DONE
                                                                          : ST_BAD_REQUEST;
                  end
                  default: begin
                     rsp_word_in.status = ST_BAD_REQUEST;
                     if (!show_ff) begin
                        rsp_word_in.entry_failed = 1'b0;
                        rsp_word_in.use_count    = '0;
                     end
                  end
               endcase
               rsp_word_in.free_count = FREE_W'(unpinned_in);
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= CNT_W'(LIVE_RESET);
         victim_ff    <= '0;
         unpinned_ff  <= CNT_W'(LIVE_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         victim_ff    <= victim_in;
         unpinned_ff  <= unpinned_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      tag_ff      <= tag_in;
      ferr_ff     <= ferr_in;
      show_ff     <= show_in;
   end

   // The free count is stale during the recount cycle after a register write.
   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RECOUNT) |-> (unpinned_ff <= live_ff))
      else $error("free count exceeds the active entry count");

   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(victim_ff) < live_ff)
      else $error("victim pointer outside the active entries");

   a_accept_to_apply: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_APPLY))
      else $error("accepted request did not move to the update cycle");

   a_result_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("result word appeared without an update cycle");

   a_alloc_unpinned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && op_ff == OP_ALLOC) |-> (sel_pin_cur == '0))
      else $error("allocation picked a pinned entry");

endmodule

`default_nettype wire

// ===== sim/tb_pinned_round_robin_block_cache.sv =====
`timescale 1ns / 1ps

module tb_pinned_round_robin_block_cache;
   import prc_pkg::*;

   localparam int SLOTS = 8;
   localparam logic [USE_W-1:0] PIN_MAX = '1;
   localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
   localparam int POOL_SIZE = 12;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 100;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam logic [ADDR_W-1:0] ADDR_A = 48'h1234_5678_9ABC;
   // Active entry setting of each random phase, phase 0 in the low nibble.
   localparam logic [4*PHASES-1:0] PHASE_ACTIVE =
      {4'd6, 4'd4, 4'd7, 4'd2, 4'd5, 4'd15, 4'd0, 4'd3, 4'd1, 4'd8};

   typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_type;

   typedef struct {
      bit               is_csr;
      logic [CSR_W-1:0] csr_val;
      req_word_type     word;
      bit               typed;
      rsp_word_type     want;
   } plan_row_type;

   logic clock;
   logic reset;

   prc_chan_if #(.word_type(req_word_type)) req_if ();
   prc_chan_if #(.word_type(rsp_word_type)) rsp_if ();
   prc_chan_if #(.word_type(csr_word_type)) csr_if ();

   pinned_round_robin_block_cache dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Shadow copy of the cache directory.
   logic [ADDR_W-1:0] model_tags  [SLOTS];
   logic              model_valid [SLOTS];
   logic [USE_W-1:0]  model_pins  [SLOTS];
   logic              model_pend  [SLOTS];
   logic              model_err   [SLOTS];
   int                model_victim;
   logic [FREE_W-1:0] model_free;
   logic [CSR_W-1:0]  model_active;

   rsp_word_type awaited_results [$];
   int mismatch_count = 0;
   int src_idle_pct = 0;
   int sink_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int model_live();
      if (model_active == 0) return 1;
      if (model_active > SLOTS) return SLOTS;
      return model_active;
   endfunction

   function automatic rsp_word_type entry_view(status_type st, int slot);
      rsp_word_type r;
      r.status       = st;
      r.entry_slot   = slot[INDEX_W-1:0];
      r.entry_failed = model_err[slot];
      r.use_count    = model_pins[slot];
      r.free_count   = model_free;
      return r;
   endfunction

   function automatic rsp_word_type predict_access(input req_word_type w);
      int n;
      int idx;
      int pos;
      rsp_word_type r;
      n   = model_live();
      idx = w.entry_index;
      r   = '0;
      case (w.req_type)
         REQ_GET: begin
            // The lowest matching entry wins when tags are duplicated.
            for (int i = 0; i < n; i++) begin
               if (model_valid[i] && model_tags[i] == w.block_addr) begin
                  if (model_pins[i] == 0 && model_free > 0) model_free--;
                  if (model_pins[i] != PIN_MAX) model_pins[i]++;
                  return entry_view(model_pend[i] ? ST_HIT_PENDING : ST_HIT_READY, i);
               end
            end
            pos = (model_victim < n) ? model_victim : 0;
            for (int k = 0; k < n; k++) begin
               if (model_pins[pos] == 0) begin
                  model_tags[pos]  = w.block_addr;
                  model_valid[pos] = 1'b1;
                  model_pins[pos]  = USE_W'(1);
                  model_pend[pos]  = 1'b1;
                  model_err[pos]   = 1'b0;
                  if (model_free > 0) model_free--;
                  model_victim = (pos + 1 < n) ? pos + 1 : 0;
                  return entry_view(ST_MISS_ALLOC, pos);
               end
               pos = (pos + 1 < n) ? pos + 1 : 0;
            end
            r.status     = ST_ALL_LOCKED;
            r.free_count = model_free;
         end
         REQ_PUT: begin
            if (idx >= n || model_pins[idx] == 0) return entry_view(ST_BAD_REQUEST, idx);
            model_pins[idx]--;
            if (model_pins[idx] == 0) begin
               model_free++;
               return entry_view(ST_RELEASED, idx);
            end
            r = entry_view(ST_STILL_HELD, idx);
         end
         REQ_FILL: begin
            if (idx >= n || !model_valid[idx] || !model_pend[idx])
               return entry_view(ST_BAD_REQUEST, idx);
            model_pend[idx] = 1'b0;
            model_err[idx]  = w.fill_error;
            r = entry_view(ST_FILL_DONE, idx);
         end
         default: begin
            r = entry_view(ST_BAD_REQUEST, idx);
         end
      endcase
      return r;
   endfunction

   function automatic plan_row_type ask(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                        logic [INDEX_W-1:0] idx, logic ferr);
      plan_row_type row;
      row.is_csr  = 1'b0;
      row.csr_val = '0;
      row.word    = {kind, addr, idx, ferr};
      row.typed   = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   function automatic plan_row_type ask_typed(logic [REQ_W-1:0] kind,
                                              logic [ADDR_W-1:0] addr,
                                              logic [INDEX_W-1:0] idx, logic ferr,
                                              status_type st, int slot, bit failed,
                                              int uses, int free_n);
      plan_row_type row;
      row       = ask(kind, addr, idx, ferr);
      row.typed = 1'b1;
      row.want  = {st, 3'(slot), failed, 8'(uses), 4'(free_n)};
      return row;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_W-1:0] value);
      plan_row_type row;
      row         = ask(REQ_GET, '0, '0, 1'b0);
      row.is_csr  = 1'b1;
      row.csr_val = value;
      return row;
   endfunction

   task automatic set_flow(flow_mode_type mode);
      case (mode)
         FLOW_FREE: begin
            src_idle_pct = 0;
            sink_stall_pct = 0;
         end
         FLOW_SRC_IDLE: begin
            src_idle_pct = 73;
            sink_stall_pct = 0;
         end
         FLOW_SINK_STALL: begin
            src_idle_pct = 0;
            sink_stall_pct = 73;
         end
         default: begin
            src_idle_pct = 20;
            sink_stall_pct = 20;
         end
      endcase
   endtask

   // Offers one request word and books its expected result once it is taken.
   task automatic push_req(input req_word_type w, input bit typed, input rsp_word_type want);
      rsp_word_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = predict_access(w);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   task automatic write_active_entries(input logic [CSR_W-1:0] value);
      int n;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.word  <= csr_word_type'(value);
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      // The free count is rebuilt over the new active range.
      model_active = value;
      n = model_live();
      model_free = '0;
      for (int i = 0; i < n; i++)
         if (model_pins[i] == 0) model_free++;
      if (model_victim >= n) model_victim = 0;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(posedge clock) begin : watch_rsp
      rsp_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result word with none expected, expected none, actual %h",
                     $time, rsp_if.word);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", want.status, rsp_if.word.status);
            check_field("entry_slot", want.entry_slot, rsp_if.word.entry_slot);
            check_field("entry_failed", want.entry_failed, rsp_if.word.entry_failed);
            check_field("use_count", want.use_count, rsp_if.word.use_count);
            check_field("free_count", want.free_count, rsp_if.word.free_count);
         end
      end
   end

   initial begin
      plan_row_type plan [$];
      rsp_word_type none;
      req_word_type w;
      logic [ADDR_W-1:0] pool [POOL_SIZE];
      logic [ADDR_W-1:0] sat_addr;
      int cand [$];
      int n;
      int sel;
      int drain;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.word = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.word = '0;
      none = '0;
      for (int i = 0; i < SLOTS; i++) begin
         model_tags[i]  = '0;
         model_valid[i] = 1'b0;
         model_pins[i]  = '0;
         model_pend[i]  = 1'b0;
         model_err[i]   = 1'b0;
      end
      model_victim = 0;
      model_active = CSR_W'(ACTIVE_RESET);
      model_free = FREE_W'(ACTIVE_RESET);
      set_flow(FLOW_FREE);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan.push_back(ask_typed(REQ_GET, 48'h0, 3'd6, 1'b1, ST_MISS_ALLOC, 0, 0, 1, 7));
      plan.push_back(ask_typed(REQ_GET, ADDR_MAX, 3'd1, 1'b0, ST_MISS_ALLOC, 1, 0, 1, 6));
      plan.push_back(ask_typed(REQ_GET, 48'h0, 3'd0, 1'b0, ST_HIT_PENDING, 0, 0, 2, 6));
      plan.push_back(ask_typed(REQ_FILL, ADDR_MAX, 3'd0, 1'b1, ST_FILL_DONE, 0, 1, 2, 6));
      plan.push_back(ask_typed(REQ_GET, 48'h0, 3'd7, 1'b1, ST_HIT_READY, 0, 1, 3, 6));
      plan.push_back(ask_typed(REQ_PUT, ADDR_A, 3'd0, 1'b0, ST_STILL_HELD, 0, 1, 2, 6));
      plan.push_back(ask_typed(REQ_PUT, ADDR_MAX, 3'd0, 1'b1, ST_STILL_HELD, 0, 1, 1, 6));
      plan.push_back(ask_typed(REQ_PUT, 48'h0, 3'd0, 1'b0, ST_RELEASED, 0, 1, 0, 7));
      // Releasing an entry that holds no pin is refused.
      plan.push_back(ask_typed(REQ_PUT, 48'h0, 3'd0, 1'b1, ST_BAD_REQUEST, 0, 1, 0, 7));
      plan.push_back(ask_typed(REQ_FILL, 48'h0, 3'd0, 1'b0, ST_BAD_REQUEST, 0, 1, 0, 7));
      plan.push_back(ask_typed(REQ_FILL, ADDR_MAX, 3'd7, 1'b1, ST_BAD_REQUEST, 7, 0, 0, 7));
      plan.push_back(ask_typed(REQ_UNDEF, ADDR_MAX, 3'd5, 1'b1, ST_BAD_REQUEST, 5, 0, 0, 7));
      plan.push_back(ask_typed(REQ_FILL, 48'h0, 3'd1, 1'b0, ST_FILL_DONE, 1, 0, 1, 7));
      plan.push_back(ask_typed(REQ_GET, ADDR_MAX, 3'd2, 1'b0, ST_HIT_READY, 1, 0, 2, 7));
      plan.push_back(ask_typed(REQ_GET, ADDR_A, 3'd0, 1'b0, ST_MISS_ALLOC, 2, 0, 1, 6));
      plan.push_back(ask_typed(REQ_GET, 48'h0, 3'd3, 1'b1, ST_HIT_READY, 0, 1, 1, 5));
      // With two active entries, both pinned, a miss finds no victim.
      plan.push_back(csr_row(4'd2));
      plan.push_back(ask_typed(REQ_GET, 48'h0000_5A5A_0001, 3'd4, 1'b0,
                               ST_ALL_LOCKED, 0, 0, 0, 0));
      plan.push_back(ask_typed(REQ_PUT, 48'h0, 3'd5, 1'b0, ST_BAD_REQUEST, 5, 0, 0, 0));
      plan.push_back(ask_typed(REQ_PUT, 48'h0, 3'd2, 1'b0, ST_BAD_REQUEST, 2, 0, 1, 0));
      plan.push_back(ask_typed(REQ_PUT, ADDR_MAX, 3'd0, 1'b1, ST_RELEASED, 0, 1, 0, 1));
      plan.push_back(ask_typed(REQ_GET, ADDR_A, 3'd1, 1'b1, ST_MISS_ALLOC, 0, 0, 1, 0));
      plan.push_back(csr_row(4'd0));
      plan.push_back(ask_typed(REQ_PUT, 48'h0, 3'd0, 1'b0, ST_RELEASED, 0, 0, 0, 1));
      plan.push_back(csr_row(4'd15));
      plan.push_back(ask_typed(REQ_GET, ADDR_A, 3'd0, 1'b0, ST_HIT_PENDING, 0, 0, 1, 5));
      plan.push_back(csr_row(4'd8));
      plan.push_back(ask(REQ_FILL, 48'h0, 3'd0, 1'b1));
      plan.push_back(ask(REQ_GET, ADDR_A, 3'd7, 1'b0));

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_active_entries(plan[i].csr_val);
         else push_req(plan[i].word, plan[i].typed, plan[i].want);
      end

      // Drive one entry into pin count saturation and back down to zero, with one more release refused at zero.
      set_flow(FLOW_SINK_STALL);
      write_active_entries(4'd1);
      while (model_pins[0] != 0) begin
         w = {REQ_PUT, 16'($urandom), 32'($urandom), 3'd0, 1'($urandom)};
         push_req(w, 1'b0, none);
      end
      sat_addr = {16'($urandom), 32'($urandom)};
      repeat (258) begin
         w = {REQ_GET, sat_addr, 3'($urandom), 1'($urandom)};
         push_req(w, 1'b0, none);
      end
      repeat (256) begin
         w = {REQ_PUT, 16'($urandom), 32'($urandom), 3'd0, 1'($urandom)};
         push_req(w, 1'b0, none);
      end

      for (int p = 0; p < PHASES; p++) begin
         set_flow(flow_mode_type'(p % 4));
         write_active_entries(PHASE_ACTIVE[4*p +: 4]);
         for (int i = 0; i < POOL_SIZE; i++) pool[i] = {16'($urandom), 32'($urandom)};
         repeat (PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            n = model_live();
            w.req_type    = REQ_GET;
            w.block_addr  = {16'($urandom), 32'($urandom)};
            w.entry_index = INDEX_W'($urandom_range(0, 7));
            w.fill_error  = 1'($urandom_range(0, 1));
            cand.delete();
            if (sel < 45) begin
               if ($urandom_range(0, 9) != 0) w.block_addr = pool[$urandom_range(0, POOL_SIZE-1)];
            end else if (sel < 78) begin
               w.req_type = REQ_PUT;
               for (int i = 0; i < n; i++)
                  if (model_pins[i] != 0) cand.push_back(i);
               if (cand.size() != 0)
                  w.entry_index = INDEX_W'(cand[$urandom_range(0, cand.size()-1)]);
            end else if (sel < 90) begin
               w.req_type = REQ_FILL;
               for (int i = 0; i < n; i++)
                  if (model_valid[i] && model_pend[i]) cand.push_back(i);
               if (cand.size() != 0)
                  w.entry_index = INDEX_W'(cand[$urandom_range(0, cand.size()-1)]);
            end else begin
               w.req_type = REQ_W'($urandom_range(0, 3));
            end
            push_req(w, 1'b0, none);
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      drain = 0;
      while (awaited_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      if (awaited_results.size() != 0) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         repeat (4) @(posedge clock);
         if (mismatch_count == 0)
            $display("[ OK ] regression clean");
         else
            $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
